@@ hdl/aes_two_round_encrypt_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the two-round AES block
// Clocked on i_clk; the reset-qualified form is disabled while i_rst_n is low.
// ----------------------------------------------------------------------------
`ifndef AES_TWO_ROUND_ENCRYPT_MACROS_SVH
`define AES_TWO_ROUND_ENCRYPT_MACROS_SVH

`ifndef NO_ASSERTIONS
`define ATRE_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);
`define ATRE_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) prop) else $error(msg);
`else
`define ATRE_ASSERT(label, prop, msg)
`define ATRE_ASSERT_ALWAYS(label, prop, msg)
`endif

`endif

@@ hdl/atre_pkg.sv @@
// ----------------------------------------------------------------------------
// atre_pkg
// Shared constants and the byte and block functions of the two-round AES block.
// ----------------------------------------------------------------------------
package atre_pkg;

    localparam int unsigned HalfW  = 64;
    localparam int unsigned BlockW = 128;

    typedef logic [BlockW-1:0] t_block;
    typedef logic [HalfW-1:0]  t_half;
    typedef logic [7:0]        t_byte;

    localparam t_byte RCON_1    = 8'h01;
    localparam t_byte RCON_2    = 8'h02;
    localparam t_byte GF_POLY   = 8'h1b;

    localparam t_byte SBOX [256] = '{
        8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,
        8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
        8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,
        8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
        8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,
        8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
        8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,
        8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
        8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,
        8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
        8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,
        8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
        8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,
        8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
        8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,
        8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
        8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,
        8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
        8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,
        8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
        8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,
        8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
        8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,
        8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
        8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,
        8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
        8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,
        8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
        8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,
        8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
        8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,
        8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
    };

    function automatic t_byte f_sbox(input t_byte a);
        return SBOX[a];
    endfunction

    function automatic t_byte f_xtime(input t_byte a);
        return {a[6:0], 1'b0} ^ (a[7] ? GF_POLY : 8'h00);
    endfunction

    // SubBytes then ShiftRows: row r of column c comes from column (c+r) mod 4.
    function automatic t_block f_sub_shift(input t_block s);
        t_block t;
        int unsigned src;
        t = '0;
        for (int unsigned c = 0; c < 4; c++) begin
            for (int unsigned r = 0; r < 4; r++) begin
                src = ((4 * (c + r)) % 16) + r;
                t[8*(4*c+r) +: 8] = f_sbox(s[8*src +: 8]);
            end
        end
        return t;
    endfunction

    function automatic t_block f_mix(input t_block s);
        t_block t;
        t_byte  a0, a1, a2, a3, all;
        t = '0;
        for (int unsigned c = 0; c < 4; c++) begin
            a0  = s[32*c      +: 8];
            a1  = s[32*c + 8  +: 8];
            a2  = s[32*c + 16 +: 8];
            a3  = s[32*c + 24 +: 8];
            all = a0 ^ a1 ^ a2 ^ a3;
            t[32*c      +: 8] = a0 ^ all ^ f_xtime(a0 ^ a1);
            t[32*c + 8  +: 8] = a1 ^ all ^ f_xtime(a1 ^ a2);
            t[32*c + 16 +: 8] = a2 ^ all ^ f_xtime(a2 ^ a3);
            t[32*c + 24 +: 8] = a3 ^ all ^ f_xtime(a3 ^ a0);
        end
        return t;
    endfunction

    function automatic t_block f_next_key(input t_block p, input t_byte rcon);
        t_block n;
        logic [31:0] w;
        w = {f_sbox(p[8*12 +: 8]), f_sbox(p[8*15 +: 8]),
             f_sbox(p[8*14 +: 8]), f_sbox(p[8*13 +: 8]) ^ rcon};
        n = '0;
        for (int unsigned i = 0; i < 4; i++) begin
            w = w ^ p[32*i +: 32];
            n[32*i +: 32] = w;
        end
        return n;
    endfunction

endpackage

@@ hdl/atre_key_expand.sv @@
// ----------------------------------------------------------------------------
// atre_key_expand
// Derives round keys 1 and 2 from the cipher key with round constants 1 and 2.
// ----------------------------------------------------------------------------
module atre_key_expand
    import atre_pkg::*;
(
    input  t_block i_key,
    output t_block o_key_1,
    output t_block o_key_2
);

    assign o_key_1 = f_next_key(i_key, RCON_1);
    assign o_key_2 = f_next_key(o_key_1, RCON_2);

endmodule

@@ hdl/atre_cipher_path.sv @@
// ----------------------------------------------------------------------------
// atre_cipher_path
// Initial key addition, one full round and one final round on a block.
// ----------------------------------------------------------------------------
module atre_cipher_path
    import atre_pkg::*;
(
    input  t_block i_block,
    input  t_block i_key_0,
    input  t_block i_key_1,
    input  t_block i_key_2,
    output t_block o_cipher
);

    t_block round_1;

    assign round_1  = f_mix(f_sub_shift(i_block ^ i_key_0)) ^ i_key_1;
    assign o_cipher = f_sub_shift(round_1) ^ i_key_2;

endmodule

@@ hdl/aes_two_round_encrypt.sv @@
// ----------------------------------------------------------------------------
// aes_two_round_encrypt
// Two-round AES-128 style encryption, one 128-bit word per cycle unless stalled.
// ----------------------------------------------------------------------------
// The input channel carries a block and a key, each as two 64-bit halves,
// byte 0 in bits 7:0 of the low half; a word is taken when i_in_valid and
// o_in_ready are both high. The output channel presents the 128-bit result
// on o_cipher_low and o_cipher_high while o_out_valid is high, and the word
// is taken when i_out_ready is high too.
// An accepted word lands in an input register; the key schedule and both
// rounds sit between that register and the result register, so a word's
// result is computed from the input register and moves into the result
// register once that register is free or being taken. One word is accepted
// and one result delivered every cycle while the receiver keeps up.
// When the receiver stalls, the result register holds its word and the
// input register can still take one more word; the input side then stalls
// until the result is taken.
// Reset clears both valid flags; no result is pending after reset.
// ----------------------------------------------------------------------------
module aes_two_round_encrypt
    import atre_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [63:0] i_block_low,
    input  logic [63:0] i_block_high,
    input  logic [63:0] i_key_low,
    input  logic [63:0] i_key_high,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [63:0] o_cipher_low,
    output logic [63:0] o_cipher_high
);

`include "aes_two_round_encrypt_macros.svh"

    logic   r_in_valid, n_in_valid;
    logic   r_out_valid, n_out_valid;
    t_block r_block, r_key;
    t_block r_cipher;
    t_block key_1, key_2, cipher;
    logic   advance;
    logic   in_fire;

    assign advance    = !r_out_valid || i_out_ready;
    assign o_in_ready = !r_in_valid || advance;
    assign in_fire    = i_in_valid && o_in_ready;

    always_comb begin
        n_in_valid = r_in_valid;
        if (o_in_ready) begin
            n_in_valid = i_in_valid;
        end
        n_out_valid = r_out_valid;
        if (advance) begin
            n_out_valid = r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_in_valid  <= n_in_valid;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_block <= {i_block_high, i_block_low};
            r_key   <= {i_key_high, i_key_low};
        end
        if (advance && r_in_valid) begin
            r_cipher <= cipher;
        end
    end

    atre_key_expand u_key_expand (
        .i_key   (r_key),
        .o_key_1 (key_1),
        .o_key_2 (key_2)
    );

    atre_cipher_path u_cipher_path (
        .i_block  (r_block),
        .i_key_0  (r_key),
        .i_key_1  (key_1),
        .i_key_2  (key_2),
        .o_cipher (cipher)
    );

    assign o_out_valid   = r_out_valid;
    assign o_cipher_low  = r_cipher[HalfW-1:0];
    assign o_cipher_high = r_cipher[BlockW-1:HalfW];

    `ATRE_ASSERT(a_stall_holds_result, r_out_valid && !i_out_ready |=> r_out_valid && $stable(r_cipher), "stalled result changed")
    `ATRE_ASSERT(a_full_blocks_input, r_in_valid && r_out_valid && !i_out_ready |-> !o_in_ready, "input taken while both stages full")
    `ATRE_ASSERT(a_word_moves_on, r_in_valid && advance |=> r_out_valid, "word lost between stages")
    `ATRE_ASSERT(a_fire_fills_input, in_fire |=> r_in_valid, "accepted word not registered")
    `ATRE_ASSERT_ALWAYS(a_reset_clears, !i_rst_n |=> !r_in_valid && !r_out_valid, "valid flags not cleared by reset")

endmodule

@@ tb/sv/tb_aes_two_round_encrypt.sv @@
// ----------------------------------------------------------------------------
// tb_aes_two_round_encrypt
// Self-checking testbench for the two-round AES-128 style encryption block.
// ----------------------------------------------------------------------------
// Every word that enters the block is run through a bit-exact model of the
// two rounds, and the result is queued. The queued result is compared with
// each word that leaves the block. The model builds its own S-box from the
// field inverse and the affine map. The stimulus starts with directed
// extremes and a standard test pattern. It goes on to random words with
// biased byte patterns, a pause that drains the pipeline, resent words, and
// a final stretch where both sides run back to back. The sender and the
// receiver idle in random bursts, and a watchdog ends a run that hangs.
// ----------------------------------------------------------------------------
module tb_aes_two_round_encrypt
    import atre_pkg::*;
();

    localparam t_byte AES_POLY     = 8'h1b;
    localparam t_byte AFFINE_C     = 8'h63;
    localparam t_byte RC_ROUND1    = 8'h01;
    localparam t_byte RC_ROUND2    = 8'h02;
    localparam int    WATCHDOG_MAX = 1000;
    localparam int    REPORT_MAX   = 10;

    localparam t_half STD_BLOCK_LO = 64'h7766554433221100;
    localparam t_half STD_BLOCK_HI = 64'hffeeddccbbaa9988;
    localparam t_half STD_KEY_LO   = 64'h0706050403020100;
    localparam t_half STD_KEY_HI   = 64'h0f0e0d0c0b0a0908;

    logic  i_clk        = 1'b0;
    logic  i_rst_n      = 1'b0;
    logic  i_in_valid   = 1'b0;
    logic  o_in_ready;
    t_half i_block_low  = '0;
    t_half i_block_high = '0;
    t_half i_key_low    = '0;
    t_half i_key_high   = '0;
    logic  o_out_valid;
    logic  i_out_ready  = 1'b0;
    t_half o_cipher_low;
    t_half o_cipher_high;

    t_byte  sbox_tbl [256];
    t_block pending_cipher [$];
    bit     idle_on     = 1'b0;
    int     stall_left  = 0;
    int     quiet_count = 0;
    int     n_words     = 0;
    int     n_results   = 0;
    int     n_errors    = 0;
    int     n_gaps      = 0;
    int     n_stalls    = 0;

    aes_two_round_encrypt dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_block_low  (i_block_low),
        .i_block_high (i_block_high),
        .i_key_low    (i_key_low),
        .i_key_high   (i_key_high),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_cipher_low (o_cipher_low),
        .o_cipher_high(o_cipher_high)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    function automatic t_byte gf_mul(input t_byte a, input t_byte b);
        t_byte prod;
        t_byte x;
        prod = '0;
        x    = a;
        for (int i = 0; i < 8; i++) begin
            if (b[i]) begin
                prod = prod ^ x;
            end
            x = {x[6:0], 1'b0} ^ (x[7] ? AES_POLY : 8'h00);
        end
        return prod;
    endfunction

    task automatic build_sbox();
        t_byte inv;
        for (int a = 0; a < 256; a++) begin
            inv = 8'h00;
            for (int b = 1; b < 256; b++) begin
                if (gf_mul(8'(a), 8'(b)) == 8'h01) begin
                    inv = 8'(b);
                end
            end
            sbox_tbl[a] = inv ^ {inv[6:0], inv[7]} ^ {inv[5:0], inv[7:6]}
                        ^ {inv[4:0], inv[7:5]} ^ {inv[3:0], inv[7:4]} ^ AFFINE_C;
        end
    endtask

    function automatic t_block next_round_key(input t_block k, input t_byte rc);
        t_byte  tw [4];
        t_block nk;
        tw[0] = sbox_tbl[k[8*13 +: 8]] ^ rc;
        tw[1] = sbox_tbl[k[8*14 +: 8]];
        tw[2] = sbox_tbl[k[8*15 +: 8]];
        tw[3] = sbox_tbl[k[8*12 +: 8]];
        for (int w = 0; w < 4; w++) begin
            for (int j = 0; j < 4; j++) begin
                tw[j] = tw[j] ^ k[8*(4*w+j) +: 8];
                nk[8*(4*w+j) +: 8] = tw[j];
            end
        end
        return nk;
    endfunction

    function automatic t_block sub_and_shift(input t_block s);
        t_block o;
        for (int c = 0; c < 4; c++) begin
            for (int r = 0; r < 4; r++) begin
                o[8*(4*c+r) +: 8] = sbox_tbl[s[8*(4*((c+r)%4)+r) +: 8]];
            end
        end
        return o;
    endfunction

    function automatic t_block column_mix(input t_block s);
        t_block o;
        t_byte  a0, a1, a2, a3;
        for (int c = 0; c < 4; c++) begin
            a0 = s[32*c      +: 8];
            a1 = s[32*c + 8  +: 8];
            a2 = s[32*c + 16 +: 8];
            a3 = s[32*c + 24 +: 8];
            o[32*c      +: 8] = gf_mul(8'h02, a0) ^ gf_mul(8'h03, a1) ^ a2 ^ a3;
            o[32*c + 8  +: 8] = a0 ^ gf_mul(8'h02, a1) ^ gf_mul(8'h03, a2) ^ a3;
            o[32*c + 16 +: 8] = a0 ^ a1 ^ gf_mul(8'h02, a2) ^ gf_mul(8'h03, a3);
            o[32*c + 24 +: 8] = gf_mul(8'h03, a0) ^ a1 ^ a2 ^ gf_mul(8'h02, a3);
        end
        return o;
    endfunction

    function automatic t_block two_round_cipher(input t_block blk, input t_block k0);
        t_block k1, k2, s;
        k1 = next_round_key(k0, RC_ROUND1);
        k2 = next_round_key(k1, RC_ROUND2);
        s  = column_mix(sub_and_shift(blk ^ k0)) ^ k1;
        return sub_and_shift(s) ^ k2;
    endfunction

    // Most halves are uniform; some have bytes forced to the corner values.
    function automatic t_half rand_half();
        t_half v;
        v = {$urandom, $urandom};
        if ($urandom_range(0, 3) == 0) begin
            for (int i = 0; i < 8; i++) begin
                case ($urandom_range(0, 4))
                    0: v[8*i +: 8] = 8'h00;
                    1: v[8*i +: 8] = 8'hff;
                    2: v[8*i +: 8] = 8'h80;
                    3: v[8*i +: 8] = 8'h01;
                    default: ;
                endcase
            end
        end
        return v;
    endfunction

    // Input and output handshakes are handled in one process, so a word that
    // is predicted and a word that is checked in the same cycle cannot race.
    always @(posedge i_clk) begin : p_scoreboard
        t_block got;
        t_block want;
        bit     in_acc;
        bit     out_acc;
        if (i_rst_n) begin
            in_acc  = i_in_valid && o_in_ready;
            out_acc = o_out_valid && i_out_ready;
            if (in_acc) begin
                pending_cipher.push_back(two_round_cipher({i_block_high, i_block_low},
                                                          {i_key_high, i_key_low}));
            end
            if (out_acc) begin
                got = {o_cipher_high, o_cipher_low};
                if (pending_cipher.size() == 0) begin
                    n_errors++;
                    if (n_errors <= REPORT_MAX) begin
                        $display("Unexpected result word: high=%h low=%h",
                                 got[127:64], got[63:0]);
                    end
                end else begin
                    want = pending_cipher.pop_front();
                    if (got[63:0] !== want[63:0] || got[127:64] !== want[127:64]) begin
                        n_errors++;
                        if (n_errors <= REPORT_MAX) begin
                            $display("Result word %0d mismatch: cipher_low exp=%h got=%h",
                                     n_results, want[63:0], got[63:0]);
                            $display("Result word %0d mismatch: cipher_high exp=%h got=%h",
                                     n_results, want[127:64], got[127:64]);
                        end
                    end
                end
                n_results++;
            end
            if (in_acc || out_acc) begin
                quiet_count = 0;
            end else begin
                quiet_count++;
                if (quiet_count >= WATCHDOG_MAX) begin
                    $display("Watchdog: no word moved for %0d cycles", quiet_count);
                    $display("Regression FAIL");
                    $finish;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (stall_left != 0) begin
            i_out_ready <= 1'b0;
            stall_left  <= stall_left - 1;
        end else if (idle_on && $urandom_range(0, 3) == 0) begin
            i_out_ready <= 1'b0;
            stall_left  <= $urandom_range(0, 3);
            n_stalls++;
        end else begin
            i_out_ready <= 1'b1;
        end
    end

    task automatic send_word(input t_half bl, input t_half bh, input t_half kl,
                             input t_half kh);
        if (idle_on && $urandom_range(0, 3) == 0) begin
            i_in_valid <= 1'b0;
            n_gaps++;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
        i_in_valid   <= 1'b1;
        i_block_low  <= bl;
        i_block_high <= bh;
        i_key_low    <= kl;
        i_key_high   <= kh;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        n_words++;
    endtask

    task automatic wait_drained();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (n_results != n_words) @(posedge i_clk);
    endtask

    task automatic test_directed_vectors();
        idle_on = 1'b1;
        send_word('0, '0, '0, '0);
        send_word('1, '1, '1, '1);
        send_word('1, '1, '0, '0);
        send_word('0, '0, '1, '1);
        send_word(STD_BLOCK_LO, STD_BLOCK_HI, STD_KEY_LO, STD_KEY_HI);
        send_word({8{8'h80}}, {8{8'h80}}, {8{8'h01}}, {8{8'h01}});
        send_word({16{4'h5}}, {16{4'ha}}, {16{4'ha}}, {16{4'h5}});
        send_word(64'h1, 64'h8000_0000_0000_0000, 64'h8000_0000_0000_0000, 64'h1);
        send_word(64'h8000_0000_0000_0000, 64'h1, 64'h1, 64'h8000_0000_0000_0000);
        send_word(64'hff, 64'hff00_0000_0000_0000, 64'hff00_0000_0000_0000, 64'hff);
        send_word(STD_BLOCK_HI, STD_BLOCK_LO, STD_KEY_HI, STD_KEY_LO);
        send_word({8{8'h63}}, {8{8'h16}}, {8{8'h1b}}, {8{8'h52}});
    endtask

    task automatic test_random_stream(input int count);
        for (int i = 0; i < count; i++) begin
            if (i % 50 == 0) begin
                idle_on = (i == 0) ? 1'b1 : (i == 50) ? 1'b0 : ($urandom_range(0, 3) != 0);
            end
            send_word(rand_half(), rand_half(), rand_half(), rand_half());
        end
    endtask

    // Results must not depend on what came before, so known words are resent
    // after the pipeline has drained and after unrelated traffic.
    task automatic test_drain_and_repeat();
        idle_on = 1'b1;
        for (int i = 0; i < 15; i++) begin
            send_word(rand_half(), rand_half(), rand_half(), rand_half());
        end
        wait_drained();
        send_word(STD_BLOCK_LO, STD_BLOCK_HI, STD_KEY_LO, STD_KEY_HI);
        for (int i = 0; i < 15; i++) begin
            send_word(rand_half(), rand_half(), rand_half(), rand_half());
        end
        send_word(STD_BLOCK_LO, STD_BLOCK_HI, STD_KEY_LO, STD_KEY_HI);
        send_word('0, '0, '0, '0);
    endtask

    task automatic test_back_to_back(input int count);
        idle_on = 1'b0;
        for (int i = 0; i < count; i++) begin
            send_word(rand_half(), rand_half(), rand_half(), rand_half());
        end
    endtask

    initial begin
        build_sbox();
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_directed_vectors();
        test_random_stream(300);
        test_drain_and_repeat();
        test_back_to_back(60);

        wait_drained();
        repeat (5) @(posedge i_clk);
        if (pending_cipher.size() != 0) begin
            $display("%0d expected results never arrived", pending_cipher.size());
            n_errors++;
        end
        $display("Encrypted %0d words: directed extremes, random, drained and resent, burst.",
                 n_words);
        $display("Checked %0d results with %0d sender gaps, %0d receiver stalls, %0d errors.",
                 n_results, n_gaps, n_stalls, n_errors);
        if (n_errors == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
